### design/thfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thfp_pkg
// Shared types and constants of the text header field parser: header kinds,
// keyword spellings and lengths, word limits.
// ----------------------------------------------------------------------------
package thfp_pkg;

	localparam int KW_COUNT    = 6;
	localparam int WORDS_KEPT  = 3;
	localparam int MAX_DIGITS  = 10;
	localparam int KW_MAXLEN   = 10;

	typedef enum logic [2:0] {
		KIND_CLIENT     = 3'd0,
		KIND_UPLOAD     = 3'd1,
		KIND_ACK        = 3'd2,
		KIND_RETRANSMIT = 3'd3,
		KIND_KEEPALIVE  = 3'd4,
		KIND_DATA       = 3'd5,
		KIND_OTHER      = 3'd6
	} kind_t;

	localparam logic [3:0]  POS_SAT  = 4'd11;
	localparam logic [2:0]  WIDX_SAT = 3'd4;
	localparam logic [3:0]  WLEN_SAT = 4'd11;
	localparam logic [33:0] INT32_TOP = 34'd2147483647;
	localparam logic [31:0] NEG_ONE  = 32'hFFFF_FFFF;
	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_NINE  = 8'h39;

	// keywords padded with spaces to ten characters, first character in the top byte
	localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
		"CLIENT    ",
		"UPLOAD    ",
		"ACK       ",
		"RETRANSMIT",
		"KEEPALIVE ",
		"DATA      "
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd6, 4'd3, 4'd10, 4'd9, 4'd4};

	typedef struct packed {
		logic  parse_status;
		kind_t header_kind;
	} result_user_t;

	typedef struct packed {
		logic [31:0] window_value;
		logic [31:0] ack_value;
		logic [31:0] number_value;
	} result_data_t;

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
		logic [3:0] p;
		p = (pos < 4'(KW_MAXLEN)) ? pos : 4'd0;
		return KW_TEXT[k][8*(KW_MAXLEN-1-int'(p)) +: 8];
	endfunction

endpackage

### design/text_header_field_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_header_field_parser
// Parses a text header line arriving one character per word and gives the
// header kind with up to three decimal fields at the end of the line.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per word in tdata[7:0]; a word with tlast
//   high ends the line and its character is ignored. m_axis gives one word per
//   line: tdata holds number, ack and window values, tuser the kind and status.
//   Words are only split at single spaces; words 1 to 3 are kept.
// Result path: the end word goes through the input register, then the
//   result register, where the result appears.
// Throughput: one character per cycle while no end word waits in the input
//   register; each character only updates small running registers (keyword
//   match bits, counters, one ten-digit accumulator built by shift and add).
// Reset: all line state returns to an empty line, both stages empty.
// Stall: while a result waits in the output register, characters keep
//   flowing; only a second end word waits in the input register until the
//   result has been taken.
// ----------------------------------------------------------------------------
module text_header_field_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // header_byte
	input  logic          s_axis_tlast,   // line_end
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [95:0]   m_axis_tdata,   // number_value, ack_value, window_value
	output logic [3:0]    m_axis_tuser    // header_kind, parse_status
);
	import thfp_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 advance;

	logic [3:0]           pos_q,   pos_n;
	logic [KW_COUNT-1:0]  alive_q, alive_n;
	logic [2:0]           widx_q,  widx_n;
	logic [3:0]           wlen_q,  wlen_n;
	logic [33:0]          acc_q,   acc_n;
	logic                 ok_q,    ok_n;
	logic                 lz_q,    lz_n;
	logic [31:0]          words_q [WORDS_KEPT];
	logic [31:0]          words_n [WORDS_KEPT];
	logic [31:0]          words_eff [WORDS_KEPT];

	logic [31:0]          wval;
	logic                 is_space;
	logic                 is_digit;
	logic [7:0]           digit;
	kind_t                kind;
	logic                 found;
	result_user_t         res_user;
	result_data_t         res_data;
	result_user_t         user_q;
	result_data_t         data_q;
	logic                 out_valid_q;

	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			byte_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
		end
	end

	// value of the word now open, as it would be closed
	always_comb begin
		if (wlen_q >= 4'd1 && wlen_q <= 4'(MAX_DIGITS) && ok_q &&
		    !(lz_q && wlen_q != 4'd1) && acc_q <= INT32_TOP)
			wval = acc_q[31:0];
		else
			wval = NEG_ONE;
		for (int i = 0; i < WORDS_KEPT; i++)
			words_eff[i] = (widx_q == 3'(i + 1)) ? wval : words_q[i];
	end

	// running update for one ordinary character
	always_comb begin
		is_space = (byte_s1 == CHAR_SPACE);
		is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
		digit    = byte_s1 - CHAR_ZERO;
		alive_n  = alive_q;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (pos_q < KW_LEN[k] && kw_char(3'(k), pos_q) != byte_s1)
				alive_n[k] = 1'b0;
		end
		pos_n   = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;
		widx_n  = widx_q;
		wlen_n  = wlen_q;
		acc_n   = acc_q;
		ok_n    = ok_q;
		lz_n    = lz_q;
		words_n = words_q;
		if (is_space) begin
			words_n = words_eff;
			widx_n  = (widx_q < WIDX_SAT) ? widx_q + 3'd1 : widx_q;
			wlen_n  = '0;
			acc_n   = '0;
			ok_n    = 1'b1;
			lz_n    = 1'b0;
		end else begin
			if (wlen_q == 4'd0 && byte_s1 == CHAR_ZERO)
				lz_n = 1'b1;
			if (is_digit) begin
				if (wlen_q < 4'(MAX_DIGITS))
					acc_n = (acc_q << 3) + (acc_q << 1) + {26'd0, digit};
			end else begin
				ok_n = 1'b0;
			end
			if (wlen_q < WLEN_SAT)
				wlen_n = wlen_q + 4'd1;
		end
	end

	// kind and fields at the end of the line
	always_comb begin
		kind  = KIND_OTHER;
		found = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!found && alive_q[k] && pos_q >= KW_LEN[k]) begin
				kind  = kind_t'(3'(k));
				found = 1'b1;
			end
		end
		res_data.number_value = NEG_ONE;
		res_data.ack_value    = NEG_ONE;
		res_data.window_value = NEG_ONE;
		res_user.header_kind  = kind;
		res_user.parse_status = 1'b1;
		unique case (kind)
			KIND_CLIENT: begin
				res_data.number_value = words_eff[0];
				res_user.parse_status = 1'b0;
			end
			KIND_UPLOAD, KIND_RETRANSMIT: begin
				res_data.number_value = words_eff[0];
				res_user.parse_status = (words_eff[0] == NEG_ONE);
			end
			KIND_ACK: begin
				res_data.ack_value    = words_eff[0];
				res_data.window_value = words_eff[1];
				res_user.parse_status = (words_eff[0] == NEG_ONE) ||
				                        (words_eff[1] == NEG_ONE);
			end
			KIND_DATA: begin
				res_data.ack_value    = words_eff[1];
				res_data.window_value = words_eff[2];
				if (words_eff[1] != NEG_ONE && words_eff[2] != NEG_ONE) begin
					res_data.number_value = words_eff[0];
					res_user.parse_status = (words_eff[0] == NEG_ONE);
				end
			end
			default: begin
				res_user.parse_status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= '1;
			widx_q  <= '0;
			wlen_q  <= '0;
			acc_q   <= '0;
			ok_q    <= 1'b1;
			lz_q    <= 1'b0;
			for (int i = 0; i < WORDS_KEPT; i++)
				words_q[i] <= NEG_ONE;
		end else if (advance) begin
			if (last_s1) begin
				pos_q   <= '0;
				alive_q <= '1;
				widx_q  <= '0;
				wlen_q  <= '0;
				acc_q   <= '0;
				ok_q    <= 1'b1;
				lz_q    <= 1'b0;
				for (int i = 0; i < WORDS_KEPT; i++)
					words_q[i] <= NEG_ONE;
			end else begin
				pos_q   <= pos_n;
				alive_q <= alive_n;
				widx_q  <= widx_n;
				wlen_q  <= wlen_n;
				acc_q   <= acc_n;
				ok_q    <= ok_n;
				lz_q    <= lz_n;
				words_q <= words_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			user_q      <= '{parse_status: 1'b1, header_kind: KIND_OTHER};
			data_q      <= '0;
		end else begin
			if (!out_valid_q || m_axis_tready)
				out_valid_q <= advance && last_s1;
			if (advance && last_s1) begin
				user_q <= res_user;
				data_q <= res_data;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams header lines into the text header field parser one character per
// word and checks every result word against the table's written result or an
// in-bench header predictor. A short table of hand-written lines comes first,
// then random keyword, number-like and noise lines, under changing stall patterns.
// ----------------------------------------------------------------------------
module testbench;
	import thfp_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic        bad;
		logic [31:0] number;
		logic [31:0] ack;
		logic [31:0] window;
	} line_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // header_byte
	logic        s_axis_tlast = 1'b0;    // line_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;           // number_value, ack_value, window_value
	logic [3:0]  m_axis_tuser;           // header_kind, parse_status

	text_header_field_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	string kw_name [6] = '{"CLIENT", "UPLOAD", "ACK", "RETRANSMIT", "KEEPALIVE", "DATA"};
	string boundary_words [6] = '{"0", "2147483647", "2147483648", "4294967295",
		"9999999999", "1000000000"};

	// header predictor state
	logic [3:0]  pos_count;
	logic [5:0]  kw_match;
	logic [2:0]  word_no;
	logic [3:0]  word_len;
	logic [33:0] word_acc;
	logic        word_all_digits;
	logic        word_zero_first;
	logic [31:0] field_words [3];

	line_result_t expected_results [$];
	string        row_text [$];
	bit           row_typed [$];
	line_result_t row_res [$];

	int chars_sent        = 0;
	int mismatches        = 0;
	int src_gap_pct       = 0;
	int sink_gap_pct      = 0;
	int sink_hold_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

	function automatic void start_word();
		word_len        = 4'd0;
		word_acc        = 34'd0;
		word_all_digits = 1'b1;
		word_zero_first = 1'b0;
	endfunction

	function automatic void start_line();
		pos_count = 4'd0;
		kw_match  = 6'h3f;
		word_no   = 3'd0;
		start_word();
		for (int i = 0; i < 3; i++) field_words[i] = NEG_ONE;
	endfunction

	function automatic logic [31:0] word_number();
		if (word_len == 4'd0 || word_len > 4'd10) return NEG_ONE;
		if (!word_all_digits) return NEG_ONE;
		if (word_zero_first && word_len != 4'd1) return NEG_ONE;
		if (word_acc > 34'd2147483647) return NEG_ONE;
		return word_acc[31:0];
	endfunction

	function automatic void store_word();
		if (word_no >= 3'd1 && word_no <= 3'd3) field_words[word_no - 3'd1] = word_number();
	endfunction

	function automatic void take_char(input logic [7:0] c);
		for (int k = 0; k < 6; k++) begin
			if (pos_count < kw_name[k].len() && kw_name[k][pos_count] != c)
				kw_match[k] = 1'b0;
		end
		if (pos_count < 4'd11) pos_count++;
		if (c == " ") begin
			store_word();
			if (word_no < 3'd4) word_no++;
			start_word();
		end else begin
			if (word_len == 4'd0 && c == "0") word_zero_first = 1'b1;
			if (c >= "0" && c <= "9") begin
				// only the first ten digits add to the value
				if (word_len < 4'd10) word_acc = word_acc * 34'd10 + 34'(c - 8'h30);
			end else begin
				word_all_digits = 1'b0;
			end
			if (word_len < 4'd11) word_len++;
		end
	endfunction

	function automatic line_result_t end_line();
		line_result_t r;
		logic found;
		store_word();
		r.kind   = KIND_OTHER;
		r.bad    = 1'b1;
		r.number = NEG_ONE;
		r.ack    = NEG_ONE;
		r.window = NEG_ONE;
		found    = 1'b0;
		// first keyword in list order that still matches and is complete wins
		for (int k = 0; k < 6; k++) begin
			if (!found && kw_match[k] && pos_count >= kw_name[k].len()) begin
				r.kind = kind_t'(k);
				found  = 1'b1;
			end
		end
		case (r.kind)
			KIND_CLIENT: begin
				r.number = field_words[0];
				r.bad    = 1'b0;
			end
			KIND_UPLOAD, KIND_RETRANSMIT: begin
				r.number = field_words[0];
				r.bad    = (r.number == NEG_ONE);
			end
			KIND_ACK: begin
				r.ack    = field_words[0];
				r.window = field_words[1];
				r.bad    = (r.ack == NEG_ONE || r.window == NEG_ONE);
			end
			KIND_DATA: begin
				r.ack    = field_words[1];
				r.window = field_words[2];
				if (r.ack == NEG_ONE || r.window == NEG_ONE) begin
					r.bad = 1'b1;
				end else begin
					r.number = field_words[0];
					r.bad    = (r.number == NEG_ONE);
				end
			end
			default: ;
		endcase
		start_line();
		return r;
	endfunction

	task automatic put_item(input logic [7:0] c, input logic last);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_line(input logic [7:0] chars [$], input bit typed,
		input line_result_t typed_res);
		line_result_t r;
		for (int i = 0; i < chars.size(); i++) begin
			put_item(chars[i], 1'b0);
			take_char(chars[i]);
		end
		// character of the end word is ignored, so send noise there
		put_item(8'($urandom_range(0, 255)), 1'b1);
		r = end_line();
		expected_results.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input string text, input bit typed, input kind_t kind,
		input logic bad, input logic [31:0] number, input logic [31:0] ack,
		input logic [31:0] window);
		line_result_t r;
		r.kind   = kind;
		r.bad    = bad;
		r.number = number;
		r.ack    = ack;
		r.window = window;
		row_text.push_back(text);
		row_typed.push_back(typed);
		row_res.push_back(r);
	endtask

	task automatic run_phase(input int target, input int src_pct, input int sink_pct);
		logic [7:0] chars [$];
		string s;
		int n, w, start;
		line_result_t none;
		src_gap_pct  = src_pct;
		sink_gap_pct = sink_pct;
		none = '0;
		while (chars_sent < target) begin
			chars.delete();
			if ($urandom_range(0, 9) == 0) begin
				// raw noise line
				repeat ($urandom_range(0, 14)) chars.push_back(8'($urandom_range(0, 255)));
			end else begin
				s = kw_name[$urandom_range(0, 5)];
				n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, s.len() - 1)) : s.len();
				for (int k = 0; k < n; k++) chars.push_back(s[k]);
				if (n > 0 && $urandom_range(0, 19) == 0)
					chars[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 19) == 0) chars.push_back(8'($urandom_range(8'h41, 8'h5a)));
				repeat ($urandom_range(0, 5)) begin
					chars.push_back(" ");
					if ($urandom_range(0, 15) == 0) chars.push_back(" ");
					w = $urandom_range(0, 9);
					case (w)
						0:       s = "";
						1, 2, 3: s = $sformatf("%0d", $urandom_range(0, 9999));
						4:       s = $sformatf("%0d", $urandom_range(0, 32'h7fffffff));
						5:       s = boundary_words[$urandom_range(0, 5)];
						6:       s = $sformatf("0%0d", $urandom_range(0, 999));
						7:       s = $sformatf("%0d%0d", $urandom_range(100000, 999999),
								$urandom_range(10000, 9999999));
						default: s = $sformatf("%0d", $urandom_range(0, 99999));
					endcase
					start = chars.size();
					for (int k = 0; k < s.len(); k++) chars.push_back(s[k]);
					if (w == 8)
						chars[start + $urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
					if (w == 9)
						repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 9) == 0) chars.push_back(" ");
			end
			send_line(chars, 1'b0, none);
		end
	endtask

	// receiver side: random back-pressure, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				sink_hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
			end
		end
	end

	// result checker
	initial begin
		result_data_t d;
		result_user_t u;
		line_result_t e;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				d = m_axis_tdata;
				u = m_axis_tuser;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: kind %0d status %0b", u.header_kind,
							u.parse_status);
				end else begin
					e = expected_results.pop_front();
					if (u.header_kind != e.kind || u.parse_status != e.bad ||
						d.number_value != e.number || d.ack_value != e.ack ||
						d.window_value != e.window) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected kind %0d status %0b nr %0d ack %0d win %0d",
								e.kind, e.bad, $signed(e.number), $signed(e.ack),
								$signed(e.window));
							$display("          actual   kind %0d status %0b nr %0d ack %0d win %0d",
								u.header_kind, u.parse_status, $signed(d.number_value),
								$signed(d.ack_value), $signed(d.window_value));
						end
					end
				end
			end
		end
	end

	initial begin
		logic [7:0] chars [$];
		start_line();

		// '#' in a row stands for a zero byte
		add_row("", 1, KIND_OTHER, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("CLIENT 2147483647", 1, KIND_CLIENT, 1'b0, 32'd2147483647, NEG_ONE, NEG_ONE);
		add_row("CLIENT", 1, KIND_CLIENT, 1'b0, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("UPLOAD 0", 1, KIND_UPLOAD, 1'b0, 32'd0, NEG_ONE, NEG_ONE);
		add_row("UPLOAD 2147483648", 1, KIND_UPLOAD, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("UPLOAD 9999999999", 1, KIND_UPLOAD, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("UPLOAD 12345678901", 1, KIND_UPLOAD, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("UPLOAD 1#", 1, KIND_UPLOAD, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("UPLOAD  5", 0, KIND_OTHER, 1'b0, '0, '0, '0);
		add_row("ACK 12 34", 1, KIND_ACK, 1'b0, NEG_ONE, 32'd12, 32'd34);
		add_row("ACK 12  34", 1, KIND_ACK, 1'b1, NEG_ONE, 32'd12, NEG_ONE);
		add_row("ACKNOWLEDGE 5 6", 0, KIND_OTHER, 1'b0, '0, '0, '0);
		add_row("AC", 1, KIND_OTHER, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("DAT", 1, KIND_OTHER, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("#CLIENT 1", 1, KIND_OTHER, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("upload 5", 1, KIND_OTHER, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("RETRANSMIT 007", 1, KIND_RETRANSMIT, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("RETRANSMIT 1000000000", 0, KIND_OTHER, 1'b0, '0, '0, '0);
		add_row("KEEPALIVE 5", 1, KIND_KEEPALIVE, 1'b1, NEG_ONE, NEG_ONE, NEG_ONE);
		add_row("DATA 1 2 3", 1, KIND_DATA, 1'b0, 32'd1, 32'd2, 32'd3);
		add_row("DATA x 2 3", 1, KIND_DATA, 1'b1, NEG_ONE, 32'd2, 32'd3);
		add_row("DATA 1 2 ", 1, KIND_DATA, 1'b1, NEG_ONE, 32'd2, NEG_ONE);
		add_row("DATA 0 4294967295 1", 1, KIND_DATA, 1'b1, NEG_ONE, NEG_ONE, 32'd1);
		add_row("CLIENT 1 2 3 4 5", 0, KIND_OTHER, 1'b0, '0, '0, '0);
		add_row("CLIENTX 5", 0, KIND_OTHER, 1'b0, '0, '0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		src_gap_pct  = 7;
		sink_gap_pct = 87;
		for (int i = 0; i < row_text.size(); i++) begin
			chars.delete();
			for (int j = 0; j < row_text[i].len(); j++)
				chars.push_back(row_text[i][j] == "#" ? 8'h00 : row_text[i][j]);
			send_line(chars, row_typed[i], row_res[i]);
		end

		run_phase(650, 7, 87);
		wait_for_results();
		run_phase(1300, 87, 7);
		// hold the output off while lines keep coming so the input backs up
		sink_hold_cycles = 400;
		run_phase(1950, 0, 0);
		wait_for_results();
		repeat (10) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
